// ===== rtl/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants for the HSV to RGB converter pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int HUE_W   = 9;
  localparam int PCT_W   = 7;
  localparam int LEVEL_W = 8;
  localparam int REM_W   = 6;

  localparam logic [HUE_W-1:0] FULL_CIRCLE = 9'd360;
  localparam logic [PCT_W-1:0] FULL_PCT    = 7'd100;
  localparam logic [REM_W-1:0] SECTOR_DEG  = 6'd60;
  localparam logic [7:0]       LEVEL_MAX   = 8'd255;
  localparam logic [12:0]      SECTOR_SPAN = 13'd6000;  // percent * degrees

  // Sector of the color wheel, 60 degrees each.
  typedef enum logic [2:0] {
    SEC_RED_YEL  = 3'd0,
    SEC_YEL_GRN  = 3'd1,
    SEC_GRN_CYAN = 3'd2,
    SEC_CYAN_BLU = 3'd3,
    SEC_BLU_MAG  = 3'd4,
    SEC_MAG_RED  = 3'd5
  } sector_t;

  // Decoded input: wrapped hue split into sector and remainder, clamped percents.
  typedef struct packed {
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] val;
    sector_t          sector;
    logic [REM_W-1:0] rem;
  } dec_t;

  // Levels before routing to channels.
  typedef struct packed {
    logic [LEVEL_W-1:0] top;
    logic [LEVEL_W-1:0] p;
    logic [LEVEL_W-1:0] q;
    logic [LEVEL_W-1:0] t;
  } levels_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } rgb_t;

  // Exact floor division by constants: drop the power-of-two factor, then
  // multiply by ceil(2^K/D) and keep bits from K up. K = numerator bits + log2 D.
  // top = (255*v) / 100    : >>2, then / 25,   13-bit numerator
  localparam int          TOP_SH  = 2;
  localparam logic [63:0] TOP_DIV = 64'd25;
  localparam int          TOP_K   = 18;
  localparam logic [63:0] TOP_MUL = ((64'd1 << TOP_K) + TOP_DIV - 64'd1) / TOP_DIV;
  // p = (255*v*(100-s)) / 10000 : >>4, then / 625, 18-bit numerator
  localparam int          P_SH    = 4;
  localparam logic [63:0] P_DIV   = 64'd625;
  localparam int          P_K     = 28;
  localparam logic [63:0] P_MUL   = ((64'd1 << P_K) + P_DIV - 64'd1) / P_DIV;
  // q, t = (255*v*f) / 600000 : >>6, then / 9375, 22-bit numerator
  localparam int          QT_SH   = 6;
  localparam logic [63:0] QT_DIV  = 64'd9375;
  localparam int          QT_K    = 36;
  localparam logic [63:0] QT_MUL  = ((64'd1 << QT_K) + QT_DIV - 64'd1) / QT_DIV;

endpackage

// ===== rtl/hsv2rgb_if.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_if
// Valid/ready channels carrying HSV requests and RGB results.
// ----------------------------------------------------------------------------
interface hsv2rgb_hsv_if;
  logic       valid;
  logic       ready;
  logic [8:0] hue;
  logic [6:0] saturation;
  logic [6:0] brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

// ===== rtl/hsv2rgb_sector.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// Wraps the hue, clamps the percents and splits the hue into sector and rest.
// ----------------------------------------------------------------------------
module hsv2rgb_sector
  import hsv2rgb_pkg::*;
(
  input  logic [HUE_W-1:0] hue,
  input  logic [PCT_W-1:0] saturation,
  input  logic [PCT_W-1:0] brightness,
  output dec_t             dec
);

  logic [HUE_W-1:0] h;

  always_comb begin
    h = (hue >= FULL_CIRCLE) ? hue - FULL_CIRCLE : hue;
    dec.sat = (saturation > FULL_PCT) ? FULL_PCT : saturation;
    dec.val = (brightness > FULL_PCT) ? FULL_PCT : brightness;
    if (h >= 9'd300) begin
      dec.sector = SEC_MAG_RED;
      dec.rem    = REM_W'(h - 9'd300);
    end else if (h >= 9'd240) begin
      dec.sector = SEC_BLU_MAG;
      dec.rem    = REM_W'(h - 9'd240);
    end else if (h >= 9'd180) begin
      dec.sector = SEC_CYAN_BLU;
      dec.rem    = REM_W'(h - 9'd180);
    end else if (h >= 9'd120) begin
      dec.sector = SEC_GRN_CYAN;
      dec.rem    = REM_W'(h - 9'd120);
    end else if (h >= 9'd60) begin
      dec.sector = SEC_YEL_GRN;
      dec.rem    = REM_W'(h - 9'd60);
    end else begin
      dec.sector = SEC_RED_YEL;
      dec.rem    = REM_W'(h);
    end
  end

endmodule

// ===== rtl/hsv2rgb_route.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_route
// Steers the four levels onto red, green and blue by color-wheel sector.
// ----------------------------------------------------------------------------
module hsv2rgb_route
  import hsv2rgb_pkg::*;
(
  input  levels_t lev,
  input  sector_t sector,
  output rgb_t    rgb
);

  always_comb begin
    case (sector)
      SEC_RED_YEL: begin
        rgb = '{red: lev.top, green: lev.t, blue: lev.p};
      end
      SEC_YEL_GRN: begin
        rgb = '{red: lev.q, green: lev.top, blue: lev.p};
      end
      SEC_GRN_CYAN: begin
        rgb = '{red: lev.p, green: lev.top, blue: lev.t};
      end
      SEC_CYAN_BLU: begin
        rgb = '{red: lev.p, green: lev.q, blue: lev.top};
      end
      SEC_BLU_MAG: begin
        rgb = '{red: lev.t, green: lev.p, blue: lev.top};
      end
      default: begin
        rgb = '{red: lev.top, green: lev.p, blue: lev.q};
      end
    endcase
  end

endmodule

// ===== rtl/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// An accepted request reaches rgb through the decode, factor, numerator, quotient and output registers.
// Throughput: one request per cycle; each stage advances when its successor
// has room, so stalls on rgb back up stage by stage and bubbles are squeezed.
// Reset: synchronous rst clears the valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input logic          clk,
  input logic          rst,
  hsv2rgb_hsv_if.sink  hsv,
  hsv2rgb_rgb_if.source rgb
);

  // Stage enables: a stage loads when it is empty or its successor loads.
  logic en1, en2, en3, en4, en5;
  logic v1, v2, v3, v4, v5;

  // Stage 1: decoded request.
  dec_t dec_next, s1;

  // Stage 2: scale factors. a = 255*v, ds = 100-s, qf = 6000 - s*rem, tf = 6000 - s*(60-rem).
  logic [14:0] a2;
  logic [6:0]  ds2;
  logic [12:0] qf2, tf2;
  sector_t     sec2;

  // Stage 3: full numerators.
  logic [14:0] a3;
  logic [21:0] pn3;
  logic [27:0] qn3, tn3;
  sector_t     sec3;

  // Stage 4: quotients by reciprocal multiplication.
  logic [26:0] top_prod;
  logic [36:0] p_prod;
  logic [44:0] q_prod, t_prod;
  levels_t     lev4;
  sector_t     sec4;

  // Stage 5: routed output register.
  rgb_t rgb_next, rgb_q;

  assign en5 = !v5 || rgb.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign hsv.ready = en1;

  hsv2rgb_sector u_sector (
    .hue        (hsv.hue),
    .saturation (hsv.saturation),
    .brightness (hsv.brightness),
    .dec        (dec_next)
  );

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= hsv.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // Stage 1: take the request.
  always_ff @(posedge clk) begin
    if (en1) begin
      s1 <= dec_next;
    end
  end

  // Stage 2: small products; s*rem and s*(60-rem) never exceed 6000.
  always_ff @(posedge clk) begin
    if (en2) begin
      a2   <= 15'(s1.val) * 15'(LEVEL_MAX);
      ds2  <= FULL_PCT - s1.sat;
      qf2  <= SECTOR_SPAN - 13'(s1.sat) * 13'(s1.rem);
      tf2  <= SECTOR_SPAN - 13'(s1.sat) * 13'(SECTOR_DEG - s1.rem);
      sec2 <= s1.sector;
    end
  end

  // Stage 3: one multiplier each for the p, q and t levels; a passes through for top.
  always_ff @(posedge clk) begin
    if (en3) begin
      a3   <= a2;
      pn3  <= 22'(a2) * 22'(ds2);
      qn3  <= 28'(a2) * 28'(qf2);
      tn3  <= 28'(a2) * 28'(tf2);
      sec3 <= sec2;
    end
  end

  // Stage 4: divide by the constant denominators. The power-of-two part is a
  // shift; the odd part is a multiply by its rounded-up reciprocal, exact for
  // every numerator the earlier stages can produce.
  assign top_prod = 27'(a3[14:TOP_SH]) * 27'(TOP_MUL);
  assign p_prod   = 37'(pn3[21:P_SH]) * 37'(P_MUL);
  assign q_prod   = 45'(qn3[27:QT_SH]) * 45'(QT_MUL);
  assign t_prod   = 45'(tn3[27:QT_SH]) * 45'(QT_MUL);

  always_ff @(posedge clk) begin
    if (en4) begin
      lev4.top <= top_prod[TOP_K +: LEVEL_W];
      lev4.p   <= p_prod[P_K +: LEVEL_W];
      lev4.q   <= q_prod[QT_K +: LEVEL_W];
      lev4.t   <= t_prod[QT_K +: LEVEL_W];
      sec4     <= sec3;
    end
  end

  // Stage 5: route by sector into the output register. Zero saturation needs
  // no special path: all four levels then equal floor(255*v/100).
  hsv2rgb_route u_route (
    .lev    (lev4),
    .sector (sec4),
    .rgb    (rgb_next)
  );

  always_ff @(posedge clk) begin
    if (en5) begin
      rgb_q <= rgb_next;
    end
  end

  assign rgb.valid = v5;
  assign rgb.red   = rgb_q.red;
  assign rgb.green = rgb_q.green;
  assign rgb.blue  = rgb_q.blue;

`ifndef SYNTHESIS
  // Remainder within a sector stays below 60 degrees.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    v1 |-> s1.rem < SECTOR_DEG)
    else $error("hue remainder out of range");

  // The two ramp factors always add up to 12000 - 60*s, that is 6000 + 60*ds.
  a_ramp_sum: assert property (@(posedge clk) disable iff (rst)
    v2 |-> 14'(qf2) + 14'(tf2) == 14'd6000 + 14'(ds2) * 14'd60)
    else $error("ramp factors inconsistent");

  // Levels are ordered: p lowest, top highest.
  a_level_order: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (lev4.p <= lev4.q) && (lev4.p <= lev4.t) &&
           (lev4.q <= lev4.top) && (lev4.t <= lev4.top))
    else $error("level ordering violated");

  // Nothing comes out right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rgb.valid)
    else $error("result valid after reset");
`endif

endmodule
